FILE: hw/rtl/lfu_pkg.sv
// Shared types and constants for the LFU cache core.
// Holds payload widths, the operation codes and the sequencer state type.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package lfu_pkg;

	localparam int KEY_W = 31;
	localparam int VAL_W = 31;
	localparam int CAP_W = 5;
	localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

	typedef enum logic {
		OP_GET = 1'b0,
		OP_PUT = 1'b1
	} op_t;

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_SCAN = 4'b0010,
		S_LAST = 4'b0100,
		S_DONE = 4'b1000
	} state_t;

endpackage

`default_nettype wire

FILE: hw/rtl/lfu_cache_core.sv
// Top level of the LFU cache: sequencer, scan datapath and result register.
// Depends on lfu_pkg and lfu_slot_ram.
`timescale 1ns / 1ps
`default_nettype none

// Key-value cache with least-frequently-used replacement, oldest use breaking ties.
//
// Request channel (req_valid / req_stall): one word is operation, key, value.
// Response channel (rsp_valid / rsp_stall): one word per request, hit and read_value.
// A word moves at a clock edge where valid is high and stall is low.
//
// Each request sweeps the slot RAM once, one entry per cycle: ENTRIES reads, the
// registered read in S_LAST, then S_DONE decides and writes the touched slot.
// With capacity 0 the sweep is skipped and the request goes straight to S_DONE.
// A new request is taken only after the previous one has left S_DONE.
//
// Recency aging of a hit or insert is deferred: the next sweep applies it to
// each entry as it passes and writes the aged rank back.
//
// Reset clears the valid marks, the pending aging and sets capacity to 16; the
// RAM itself is not cleared. A stalled response holds in its register; the next
// request is still taken and its sweep runs, but its result waits for the slot.
// Write capacity through capacity_we / capacity_wdata only while idle; the core does not enforce it.

module lfu_cache_core #(
	parameter int ENTRIES    = 16,
	parameter int COUNT_BITS = 16
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      capacity_we,
	input  wire logic [lfu_pkg::CAP_W-1:0] capacity_wdata,
	input  wire logic                      req_valid,
	output logic                           req_stall,
	input  wire logic                      operation,
	input  wire logic [lfu_pkg::KEY_W-1:0] key,
	input  wire logic [lfu_pkg::VAL_W-1:0] value,
	output logic                           rsp_valid,
	input  wire logic                      rsp_stall,
	output logic                           hit,
	output logic      [lfu_pkg::VAL_W-1:0] read_value
);

	localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int RANK_W = IDX_W;
	localparam int USED_W = $clog2(ENTRIES + 1);
	localparam int CMP_W  = (USED_W > lfu_pkg::CAP_W) ? USED_W : lfu_pkg::CAP_W;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

	typedef struct packed {
		logic [lfu_pkg::KEY_W-1:0] key;
		logic [lfu_pkg::VAL_W-1:0] data;
		logic [COUNT_BITS-1:0]     count;
		logic [RANK_W-1:0]         rank;
	} slot_word_t;

	localparam int WORD_W = $bits(slot_word_t);

	lfu_pkg::state_t state_q;

	logic [lfu_pkg::CAP_W-1:0] capacity_q;
	logic [ENTRIES-1:0]        valid_q;

	// request being worked
	logic                      op_q;
	logic [lfu_pkg::KEY_W-1:0] key_q;
	logic [lfu_pkg::VAL_W-1:0] val_q;
	logic                      skip_q;

	// sweep
	logic [IDX_W-1:0] rd_idx_q;
	logic             rvld_s1;
	logic [IDX_W-1:0] ridx_s1;

	// deferred recency aging
	logic              pend_q;
	logic [IDX_W-1:0]  pend_slot_q;
	logic [RANK_W-1:0] pend_bound_q;

	// scan results
	logic                      found_q;
	logic [IDX_W-1:0]          found_idx_q;
	logic [lfu_pkg::VAL_W-1:0] found_data_q;
	logic [COUNT_BITS-1:0]     found_count_q;
	logic [RANK_W-1:0]         found_rank_q;
	logic                      vict_any_q;
	logic [IDX_W-1:0]          vict_idx_q;
	logic [COUNT_BITS-1:0]     vict_count_q;
	logic [RANK_W-1:0]         vict_rank_q;
	logic                      free_any_q;
	logic [IDX_W-1:0]          free_idx_q;
	logic [USED_W-1:0]         used_q;

	// response register
	logic                      rsp_valid_q;
	logic                      hit_q;
	logic [lfu_pkg::VAL_W-1:0] read_value_q;

	// RAM ports
	logic              ram_we;
	logic [IDX_W-1:0]  ram_waddr;
	slot_word_t        ram_wdata;
	logic              ram_re;
	logic [WORD_W-1:0] ram_rdata;

	slot_word_t        entry_s1;
	logic              ent_valid;
	logic              ent_aged;
	logic [RANK_W-1:0] ent_rank;
	logic              ent_match;
	logic              ent_beats;

	logic              accept;
	logic              done_fire;
	logic              is_put;
	logic              full;
	logic              final_we;
	logic [IDX_W-1:0]  final_idx;
	slot_word_t        final_word;
	logic [RANK_W-1:0] final_bound;

	assign accept    = req_valid && !req_stall;
	assign req_stall = (state_q != lfu_pkg::S_IDLE);
	assign done_fire = (state_q == lfu_pkg::S_DONE) && (!rsp_valid_q || !rsp_stall);
	assign is_put    = (op_q == lfu_pkg::OP_PUT);

	assign rsp_valid  = rsp_valid_q;
	assign hit        = hit_q;
	assign read_value = read_value_q;

	lfu_slot_ram #(
		.DEPTH  (ENTRIES),
		.WIDTH  (WORD_W),
		.ADDR_W (IDX_W)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (WORD_W'(ram_wdata)),
		.re    (ram_re),
		.raddr (rd_idx_q),
		.rdata (ram_rdata)
	);

	assign ram_re   = (state_q == lfu_pkg::S_SCAN);
	assign entry_s1 = slot_word_t'(ram_rdata);

	// Entry coming out of the RAM: apply pending aging, then match and rank it.
	always_comb begin
		ent_valid = rvld_s1 && valid_q[ridx_s1];
		ent_aged  = pend_q && ent_valid && (ridx_s1 != pend_slot_q) &&
			(entry_s1.rank < pend_bound_q);
		ent_rank  = ent_aged ? entry_s1.rank + 1'b1 : entry_s1.rank;
		ent_match = ent_valid && !found_q && (entry_s1.key == key_q);
		ent_beats = ent_valid && (!vict_any_q || (entry_s1.count < vict_count_q) ||
			((entry_s1.count == vict_count_q) && (ent_rank > vict_rank_q)));
	end

	// Decide the touched slot once the sweep is complete.
	always_comb begin
		full        = (CMP_W'(used_q) >= CMP_W'(capacity_q)) || !free_any_q;
		final_we    = done_fire && !skip_q && (found_q || is_put);
		final_idx   = free_idx_q;
		final_bound = used_q[RANK_W-1:0];
		final_word.key   = key_q;
		final_word.data  = val_q;
		final_word.count = COUNT_BITS'(1);
		final_word.rank  = '0;
		if (found_q) begin
			final_idx        = found_idx_q;
			final_bound      = found_rank_q;
			final_word.data  = is_put ? val_q : found_data_q;
			final_word.count = (&found_count_q) ? found_count_q : found_count_q + 1'b1;
		end else if (full) begin
			final_idx   = vict_idx_q;
			final_bound = vict_rank_q;
		end
	end

	// Write port: aged write-back during the sweep, touched slot at the end.
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = ridx_s1;
		ram_wdata = entry_s1;
		ram_wdata.rank = ent_rank;
		if (final_we) begin
			ram_we    = 1'b1;
			ram_waddr = final_idx;
			ram_wdata = final_word;
		end else if (ent_aged) begin
			ram_we = 1'b1;
		end
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= lfu_pkg::S_IDLE;
			rd_idx_q <= '0;
			rvld_s1  <= 1'b0;
		end else begin
			rvld_s1 <= ram_re;
			unique case (state_q)
				lfu_pkg::S_IDLE: begin
					if (accept) begin
						rd_idx_q <= '0;
						state_q  <= (capacity_q == '0) ? lfu_pkg::S_DONE : lfu_pkg::S_SCAN;
					end
				end
				lfu_pkg::S_SCAN: begin
					if (rd_idx_q == LAST_IDX) begin
						state_q <= lfu_pkg::S_LAST;
					end else begin
						rd_idx_q <= rd_idx_q + 1'b1;
					end
				end
				lfu_pkg::S_LAST: begin
					state_q <= lfu_pkg::S_DONE;
				end
				lfu_pkg::S_DONE: begin
					if (done_fire) begin
						state_q <= lfu_pkg::S_IDLE;
					end
				end
				default: begin
					state_q <= lfu_pkg::S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		ridx_s1 <= rd_idx_q;
		if (accept) begin
			op_q   <= operation;
			key_q  <= key;
			val_q  <= value;
			skip_q <= (capacity_q == '0);
		end
	end

	// Capacity register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= lfu_pkg::CAP_RESET;
		end else if (capacity_we) begin
			capacity_q <= capacity_wdata;
		end
	end

	// Scan accumulators: clear on accept, fold in one entry per cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q    <= 1'b0;
			vict_any_q <= 1'b0;
			free_any_q <= 1'b0;
			used_q     <= '0;
		end else if (accept) begin
			found_q    <= 1'b0;
			vict_any_q <= 1'b0;
			free_any_q <= 1'b0;
			used_q     <= '0;
		end else if (rvld_s1) begin
			if (ent_match) begin
				found_q <= 1'b1;
			end
			if (ent_beats) begin
				vict_any_q <= 1'b1;
			end
			if (!ent_valid && !free_any_q) begin
				free_any_q <= 1'b1;
			end
			if (ent_valid) begin
				used_q <= used_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ent_match) begin
			found_idx_q   <= ridx_s1;
			found_data_q  <= entry_s1.data;
			found_count_q <= entry_s1.count;
			found_rank_q  <= ent_rank;
		end
		if (ent_beats) begin
			vict_idx_q   <= ridx_s1;
			vict_count_q <= entry_s1.count;
			vict_rank_q  <= ent_rank;
		end
		if (rvld_s1 && !ent_valid && !free_any_q) begin
			free_idx_q <= ridx_s1;
		end
	end

	// Valid marks and pending aging: a sweep consumes the old aging, the
	// touched slot arms the next one.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			pend_q  <= 1'b0;
		end else if (done_fire && !skip_q) begin
			pend_q <= final_we;
			if (final_we) begin
				valid_q[final_idx] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (final_we) begin
			pend_slot_q  <= final_idx;
			pend_bound_q <= final_bound;
		end
	end

	// Response register: load on decide, drop when taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (done_fire) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done_fire) begin
			hit_q        <= !skip_q && found_q;
			read_value_q <= (!skip_q && found_q && !is_put) ? found_data_q : '0;
		end
	end

`ifndef SYNTHESIS
	a_value_only_on_hit: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && (read_value_q != '0)) |-> hit_q)
		else $error("read_value nonzero without hit");

	a_pend_slot_valid: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q |-> valid_q[pend_slot_q])
		else $error("pending aging points at an empty slot");

	a_victim_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		(done_fire && !skip_q && !found_q && is_put && full) |-> vict_any_q)
		else $error("eviction without a victim");

	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == lfu_pkg::S_DONE) |-> (used_q <= USED_W'(ENTRIES)))
		else $error("occupancy count beyond entries");

	a_done_gives_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		done_fire |=> (rsp_valid_q && (state_q == lfu_pkg::S_IDLE)))
		else $error("decide did not load the response");
`endif

endmodule

`default_nettype wire

FILE: hw/rtl/lfu_slot_ram.sv
// Slot store of the LFU cache: one write port, one read port, registered read data.
// Generic in depth and word width; no package dependency.
`timescale 1ns / 1ps
`default_nettype none

module lfu_slot_ram #(
	parameter int DEPTH  = 16,
	parameter int WIDTH  = 82,
	parameter int ADDR_W = 4
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [ADDR_W-1:0] waddr,
	input  wire logic [WIDTH-1:0]  wdata,
	input  wire logic              re,
	input  wire logic [ADDR_W-1:0] raddr,
	output logic      [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

FILE: tb/lfu_cache_mirror_pkg.sv
// Behavioral mirror of the LFU cache used by the testbench to predict replies.
// Holds the slot table, the capacity copy and the queue of awaited reply words.
// Depends on lfu_pkg.
`timescale 1ns / 1ps

package lfu_cache_mirror_pkg;
	import lfu_pkg::*;

	localparam int ENTRIES    = 16;
	localparam int COUNT_BITS = 16;
	localparam int COUNT_MAX  = (1 << COUNT_BITS) - 1;

	typedef struct {
		logic             hit;
		logic [VAL_W-1:0] read_value;
	} reply_t;

	class cache_mirror;
		int unsigned      capacity;
		bit               slot_valid [ENTRIES];
		logic [KEY_W-1:0] slot_key   [ENTRIES];
		logic [VAL_W-1:0] slot_data  [ENTRIES];
		int unsigned      use_count  [ENTRIES];
		int unsigned      recency    [ENTRIES];
		reply_t           awaited_replies[$];
		int               errors;

		function new();
			capacity = CAP_RESET;
			errors = 0;
			foreach (slot_valid[i]) begin
				slot_valid[i] = 1'b0;
				slot_key[i] = '0;
				slot_data[i] = '0;
				use_count[i] = 0;
				recency[i] = 0;
			end
		endfunction

		function void set_capacity(logic [CAP_W-1:0] c);
			capacity = c;
		endfunction

		function int pending();
			return awaited_replies.size();
		endfunction

		// Make slot s the youngest; valid slots younger than old_rank age by one.
		function void promote(int s, int unsigned old_rank);
			for (int i = 0; i < ENTRIES; i++) begin
				if (slot_valid[i] && i != s && recency[i] < old_rank)
					recency[i]++;
			end
			recency[s] = 0;
		endfunction

		function void apply_request(op_t op, logic [KEY_W-1:0] k, logic [VAL_W-1:0] v);
			reply_t      r;
			int unsigned lim;
			int unsigned used;
			int          found;
			int          free_slot;
			int          victim;
			r.hit = 1'b0;
			r.read_value = '0;
			lim = (capacity > ENTRIES) ? ENTRIES : capacity;
			used = 0;
			found = -1;
			free_slot = -1;
			victim = -1;
			if (lim != 0) begin
				for (int i = 0; i < ENTRIES; i++) begin
					if (slot_valid[i]) begin
						used++;
						if (found < 0 && slot_key[i] == k)
							found = i;
						if (victim < 0 || use_count[i] < use_count[victim] ||
						    (use_count[i] == use_count[victim] &&
						     recency[i] > recency[victim]))
							victim = i;
					end else if (free_slot < 0) begin
						free_slot = i;
					end
				end
				if (found >= 0) begin
					r.hit = 1'b1;
					if (op == OP_PUT)
						slot_data[found] = v;
					else
						r.read_value = slot_data[found];
					if (use_count[found] < COUNT_MAX)
						use_count[found]++;
					promote(found, recency[found]);
				end else if (op == OP_PUT) begin
					if (used >= lim || free_slot < 0) begin
						slot_key[victim] = k;
						slot_data[victim] = v;
						use_count[victim] = 1;
						promote(victim, recency[victim]);
					end else begin
						slot_valid[free_slot] = 1'b1;
						slot_key[free_slot] = k;
						slot_data[free_slot] = v;
						use_count[free_slot] = 1;
						promote(free_slot, used);
					end
				end
			end
			awaited_replies.push_back(r);
		endfunction

		task report(string what);
			errors++;
			$display("[%0t] mismatch: %s", $time, what);
		endtask

		task check_reply(logic h, logic [VAL_W-1:0] rv);
			reply_t e;
			if (awaited_replies.size() == 0) begin
				report($sformatf("reply word with none awaited (hit=%0b value=%0h)", h, rv));
			end else begin
				e = awaited_replies.pop_front();
				if (h !== e.hit)
					report($sformatf("hit %0b, awaited %0b", h, e.hit));
				if (rv !== e.read_value)
					report($sformatf("read_value %0h, awaited %0h", rv, e.read_value));
			end
		endtask
	endclass

endpackage

FILE: tb/tb.sv
// Top-level testbench for lfu_cache_core: clock, reset, request and reply drivers.
// Predicts every reply word with cache_mirror from lfu_cache_mirror_pkg.
// Depends on lfu_pkg, lfu_cache_mirror_pkg and the lfu_cache_core RTL.
`timescale 1ns / 1ps

module tb;
	import lfu_pkg::*;
	import lfu_cache_mirror_pkg::*;

	// Sweep length of one request plus margin; used for settle waits.
	localparam int SETTLE = 2 * ENTRIES + 8;
	localparam int POOL = 24;
	localparam int PHASES = 11;

	typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              capacity_we = 1'b0;
	logic [CAP_W-1:0]  capacity_wdata = '0;
	logic              req_valid = 1'b0;
	logic              req_stall;
	logic              operation = 1'b0;
	logic [KEY_W-1:0]  key = '0;
	logic [VAL_W-1:0]  value = '0;
	logic              rsp_valid;
	logic              rsp_stall = 1'b0;
	logic              hit;
	logic [VAL_W-1:0]  read_value;

	cache_mirror board = new();

	// Idle odds in percent per cycle, set by the stimulus phase.
	int send_pct = 0;
	int rcv_pct = 0;

	// Long receiver hold-off: stimulus bumps hold_seq, the reply side counts.
	int hold_seq = 0;
	int hold_seen = 0;
	int hold_left = 0;

	logic [KEY_W-1:0] key_pool [POOL];

	lfu_cache_core #(
		.ENTRIES   (ENTRIES),
		.COUNT_BITS(COUNT_BITS)
	) u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.capacity_we   (capacity_we),
		.capacity_wdata(capacity_wdata),
		.req_valid     (req_valid),
		.req_stall     (req_stall),
		.operation     (operation),
		.key           (key),
		.value         (value),
		.rsp_valid     (rsp_valid),
		.rsp_stall     (rsp_stall),
		.hit           (hit),
		.read_value    (read_value)
	);

	// 2 ns period: high for 1 ns, low for 1 ns.
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Sample both channels at the rising edge. Check the reply first so that a
	// reply word never pairs with a request taken at the same edge.
	always @(posedge clk) begin
		if (arst_n) begin
			if (rsp_valid && !rsp_stall)
				board.check_reply(hit, read_value);
			if (req_valid && !req_stall)
				board.apply_request(op_t'(operation), key, value);
		end
	end

	// Reply side: drive stall at the falling edge. A pending hold-off request
	// wins over the random stall and keeps stall high for a long stretch, so
	// the core fills up and pushes back on its request port.
	always @(negedge clk) begin
		if (hold_seen != hold_seq) begin
			hold_seen = hold_seq;
			hold_left = 400;
		end
		if (hold_left > 0) begin
			hold_left--;
			rsp_stall <= 1'b1;
		end else begin
			rsp_stall <= ($urandom_range(99) < rcv_pct);
		end
	end

	function automatic logic [30:0] rand31();
		logic [31:0] r;
		r = $urandom;
		return r[30:0];
	endfunction

	function automatic void set_idle(idle_mode_t m);
		case (m)
			IDLE_NONE: begin send_pct = 0;  rcv_pct = 0;  end
			IDLE_SEND: begin send_pct = 49; rcv_pct = 0;  end
			IDLE_RECV: begin send_pct = 0;  rcv_pct = 49; end
			default:   begin send_pct = 8;  rcv_pct = 8;  end
		endcase
	endfunction

	// Offer one request word; return right after the edge that takes it.
	// Valid stays high into the next call, so back-to-back words see no gap.
	task automatic send_word(op_t op, logic [KEY_W-1:0] k, logic [VAL_W-1:0] v);
		int gap;
		gap = 0;
		while ($urandom_range(99) < send_pct)
			gap++;
		@(negedge clk);
		while (gap > 0) begin
			req_valid <= 1'b0;
			gap--;
			@(negedge clk);
		end
		req_valid <= 1'b1;
		operation <= op;
		key <= k;
		value <= v;
		do
			@(posedge clk);
		while (req_stall);
	endtask

	// Drop valid, wait for every awaited reply, then let extra cycles pass.
	task automatic drain(int extra);
		@(negedge clk);
		req_valid <= 1'b0;
		while (board.pending() != 0)
			@(posedge clk);
		repeat (extra)
			@(negedge clk);
	endtask

	// Write capacity only while the core is idle.
	task automatic set_capacity(logic [CAP_W-1:0] c);
		drain(SETTLE);
		capacity_we <= 1'b1;
		capacity_wdata <= c;
		board.set_capacity(c);
		@(negedge clk);
		capacity_we <= 1'b0;
	endtask

	// Mostly keys from a small pool so lookups hit and counts build up; the
	// rest are fresh keys, some of which replace pool members.
	task automatic send_random_word();
		op_t              op;
		logic [KEY_W-1:0] k;
		op = op_t'($urandom_range(1));
		if ($urandom_range(99) < 75) begin
			k = key_pool[$urandom_range(POOL - 1)];
		end else begin
			k = rand31();
			if ($urandom_range(3) == 0)
				key_pool[$urandom_range(POOL - 1)] = k;
		end
		send_word(op, k, rand31());
	endtask

	initial begin
		int         phase_cap   [PHASES];
		idle_mode_t phase_mode  [PHASES];
		int         phase_items [PHASES];
		phase_cap   = '{16, 16, 5, 1, 31, 0, 8, 16, 3, 20, 16};
		phase_mode  = '{IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH, IDLE_NONE, IDLE_SEND,
		                IDLE_BOTH, IDLE_RECV, IDLE_NONE, IDLE_BOTH, IDLE_NONE};
		phase_items = '{200, 200, 200, 120, 200, 80, 200, 220, 150, 180, 200};
		foreach (key_pool[i])
			key_pool[i] = rand31();

		// Hold reset, then release it at a falling edge.
		repeat (5)
			@(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed part, no idling, capacity at its reset value.
		set_idle(IDLE_NONE);
		send_word(OP_PUT, 31'h7FFF_FFFF, 31'h7FFF_FFFF);
		send_word(OP_PUT, 31'h0, 31'h0);
		send_word(OP_GET, 31'h7FFF_FFFF, 31'h0);
		send_word(OP_GET, 31'h0, 31'h7FFF_FFFF);
		send_word(OP_GET, 31'h1234_5678, 31'h0);
		send_word(OP_PUT, 31'h0, 31'h5555_5555);
		send_word(OP_GET, 31'h0, 31'h0);
		send_word(OP_PUT, 31'h2AAA_AAAA, 31'h2AAA_AAAA);
		send_word(OP_PUT, 31'h5555_5555, 31'h5555_5555);

		// Capacity zero: lookups miss, inserts are dropped, contents kept.
		set_capacity(5'd0);
		send_word(OP_GET, 31'h0, 31'h0);
		send_word(OP_PUT, 31'h11, 31'h11);

		// Lower capacity below occupancy: each new key evicts one entry,
		// survivors stay visible.
		set_capacity(5'd2);
		send_word(OP_PUT, 31'h100, 31'h1);
		send_word(OP_GET, 31'h7FFF_FFFF, 31'h0);
		send_word(OP_GET, 31'h0, 31'h0);
		send_word(OP_GET, 31'h100, 31'h0);
		send_word(OP_PUT, 31'h200, 31'h2);
		send_word(OP_GET, 31'h11, 31'h0);

		// Capacity above the table size acts as the table size.
		set_capacity(5'd31);
		for (int i = 0; i < 6; i++)
			send_word(OP_PUT, 31'h300 + i, rand31());

		set_capacity(5'd1);
		send_word(OP_PUT, 31'h400, 31'h4);
		send_word(OP_GET, 31'h400, 31'h0);

		// Random phases, each with its own capacity and idle pattern.
		for (int p = 0; p < PHASES; p++) begin
			set_capacity(phase_cap[p][CAP_W-1:0]);
			set_idle(phase_mode[p]);
			for (int n = 0; n < phase_items[p]; n++) begin
				// Hold replies off for a long stretch while requests keep coming.
				if (p == 0 && n == 100)
					hold_seq++;
				// Stop offering until every awaited reply is back.
				if (p == 4 && n == 100)
					drain(0);
				send_random_word();
			end
		end

		drain(SETTLE);
		if (board.errors == 0) begin
			$display("** lfu_cache_core: PASSED **");
		end else begin
			$display("** lfu_cache_core: FAILED **");
		end
		$finish;
	end

	// Hard stop well past the slowest correct run.
	initial begin
		#1_000_000;
		$display("** lfu_cache_core: FAILED **");
		$finish;
	end

endmodule

FILE: sim.f
hw/rtl/lfu_pkg.sv
hw/rtl/lfu_slot_ram.sv
hw/rtl/lfu_cache_core.sv
tb/lfu_cache_mirror_pkg.sv
tb/tb.sv
